// File: hw/rtl/dwm_pkg.sv
package dwm_pkg;

    // fixed field widths of the item ports
    localparam int POS_W          = 11;
    localparam int VAL_W          = 16;
    localparam int WORD_BITS      = 64;

    // parameter defaults
    localparam int VALUE_BITS_DEF = 16;
    localparam int MAX_LEN_DEF    = 1024;

    typedef enum logic [2:0] {
        ACT_INSERT   = 3'd0,
        ACT_ERASE    = 3'd1,
        ACT_EQ       = 3'd2,
        ACT_BELOW    = 3'd3,
        ACT_RANGE    = 3'd4,
        ACT_KTH      = 3'd5,
        ACT_LEAST    = 3'd6,
        ACT_GREATEST = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP_RD,
        ST_SWEEP_ACC,
        ST_LEVEL,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        WALK_EQ,
        WALK_BELOW,
        WALK_KTH
    } walk_t;

    typedef struct packed {
        action_t            action;
        logic [POS_W-1:0]   pos_or_rank;
        logic [POS_W-1:0]   range_start;
        logic [POS_W-1:0]   range_end;
        logic [VAL_W-1:0]   value_low;
        logic [VAL_W-1:0]   value_high;
    } req_item_t;

    typedef struct packed {
        logic [POS_W-1:0]   count_result;
        logic [VAL_W-1:0]   value_result;
        logic               found;
        logic               error;
        logic [POS_W-1:0]   length_now;
    } rsp_item_t;

    // ones in a 64-bit word
    function automatic logic [6:0] popcnt64(input logic [WORD_BITS-1:0] v);
        logic [6:0] c;
        c = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            c = c + 7'(v[i]);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/dynamic_wavelet_matrix.sv
// channel | signals                      | direction | accepted when
// req     | req_valid, req_stall, req    | in        | req_valid && !req_stall
// rsp     | rsp_valid, rsp_stall, rsp    | out       | rsp_valid && !rsp_stall
//
// one item at a time; every item gives exactly one rsp item
// a walk visits every level and reads the words up to the range end through the
// single plane ram port, one 64-bit word at a time
// insert and erase also rewrite the words they shift at each level; range, least and
// greatest queries may take two walks
// reset clears length and zero counts; the planes need no clearing since bits
// at or past the length are never observed
// a finished result waits in the rsp register while the next req item is taken
module dynamic_wavelet_matrix
    import dwm_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_LEN    = MAX_LEN_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int PW  = $clog2(MAX_LEN + 1);          // position width
    localparam int PWH = PW - 6;                       // word part of a position
    localparam int NW  = (MAX_LEN + 63) / 64;          // words per plane
    localparam int WW  = (NW > 1) ? $clog2(NW) : 1;
    localparam int LW  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int AW  = LW + WW;
    localparam int CW  = (PW > POS_W) ? PW : POS_W;    // compare width for raw fields
    localparam int IW  = (VALUE_BITS > VAL_W) ? VALUE_BITS : VAL_W;
    localparam logic [VALUE_BITS-1:0] TOP = {VALUE_BITS{1'b1}};

    // control state
    state_t                state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PW-1:0]         len_reg, len_next;
    logic [PW-1:0]         zc_reg  [VALUE_BITS];
    logic [PW-1:0]         zc_next [VALUE_BITS];

    // item and walk registers
    action_t               act_reg, act_next;
    logic [PW-1:0]         l0_reg, l0_next, r0_reg, r0_next;
    logic [VALUE_BITS-1:0] x_reg, x_next;
    logic                  second_reg, second_next;
    walk_t                 mode_reg, mode_next;
    logic [VALUE_BITS-1:0] wv_reg, wv_next;
    logic [PW-1:0]         k_reg, k_next;
    logic [LW-1:0]         lv_reg, lv_next;
    logic [WW-1:0]         w_reg, w_next;
    logic [PW-1:0]         la_reg, la_next, rb_reg, rb_next;
    logic [PW-1:0]         onesa_reg, onesa_next, onesb_reg, onesb_next;
    logic [PW-1:0]         cnt_reg, cnt_next, tmp_reg, tmp_next;
    logic [VALUE_BITS-1:0] ans_reg, ans_next;
    logic                  carry_reg, carry_next, bit_reg, bit_next;
    logic [PW-1:0]         dcnt_reg, dcnt_next;
    logic [VALUE_BITS-1:0] dval_reg, dval_next;
    logic                  dfound_reg, dfound_next, derr_reg, derr_next;
    rsp_item_t             out_reg, out_next;

    // plane ram
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

    dwm_plane_ram #(.AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign ram_addr = {lv_reg, w_reg};

    // request decode
    logic [CW-1:0]         pkc, lc, rc, lenc, maxc, spanc;
    logic [IW-1:0]         xw, yw;
    logic [VALUE_BITS-1:0] req_x, req_y;

    assign pkc   = CW'(req.pos_or_rank);
    assign lc    = CW'(req.range_start);
    assign rc    = CW'(req.range_end);
    assign lenc  = CW'(len_reg);
    assign maxc  = CW'(MAX_LEN);
    assign spanc = rc - lc;
    assign xw    = IW'(req.value_low);
    assign yw    = IW'(req.value_high);
    assign req_x = xw[VALUE_BITS-1:0];
    assign req_y = yw[VALUE_BITS-1:0];

    // word masks for ranks below la and rb
    logic [PWH-1:0]       wcur;
    logic [WORD_BITS-1:0] low_a, low_b, mask_a, mask_b;
    logic [PW-1:0]        pop_a, pop_b, rb_m1, len_m1;
    logic [WW-1:0]        sweep_last, k_word, ins_last, ers_first;

    assign wcur   = PWH'(w_reg);
    assign low_a  = (64'd1 << la_reg[5:0]) - 64'd1;
    assign low_b  = (64'd1 << rb_reg[5:0]) - 64'd1;
    assign mask_a = (wcur < la_reg[PW-1:6]) ? '1 : ((wcur == la_reg[PW-1:6]) ? low_a : '0);
    assign mask_b = (wcur < rb_reg[PW-1:6]) ? '1 : ((wcur == rb_reg[PW-1:6]) ? low_b : '0);
    assign pop_a  = PW'(popcnt64(ram_rdata & mask_a));
    assign pop_b  = PW'(popcnt64(ram_rdata & mask_b));

    assign rb_m1      = rb_reg - PW'(1);
    assign len_m1     = len_reg - PW'(1);
    assign sweep_last = (rb_reg == '0) ? '0 : WW'(rb_m1[PW-1:6]);
    assign k_word     = WW'(la_reg[PW-1:6]);
    assign ins_last   = WW'(len_reg[PW-1:6]);
    assign ers_first  = WW'(len_m1[PW-1:6]);

    // per-level arithmetic
    logic [PW-1:0] zc_cur, zl, zr, one_l, one_r, span;

    assign zc_cur = zc_reg[lv_reg];
    assign zl     = la_reg - onesa_reg;
    assign zr     = rb_reg - onesb_reg;
    assign one_l  = zc_cur + onesa_reg;
    assign one_r  = zc_cur + onesb_reg;
    assign span   = zr - zl;

    // shift word building
    logic [WORD_BITS-1:0] bit_k, ins_word, ers_word, up_shift, dn_shift;

    assign bit_k    = 64'd1 << la_reg[5:0];
    assign up_shift = {ram_rdata[WORD_BITS-2:0], carry_reg};
    assign dn_shift = {carry_reg, ram_rdata[WORD_BITS-1:1]};
    assign ins_word = (ram_rdata & low_a)
                    | ({ram_rdata[WORD_BITS-2:0], 1'b0} & ~low_a & ~bit_k)
                    | (x_reg[lv_reg] ? bit_k : '0);
    assign ers_word = (ram_rdata & low_a) | (dn_shift & ~low_a);

    // output field conversion
    logic [CW-1:0] cnt_w, len_w;
    logic [IW-1:0] val_w;

    assign cnt_w = CW'(dcnt_reg);
    assign len_w = CW'(len_reg);
    assign val_w = IW'(dval_reg);

    // walk start request
    logic                  start_walk;
    walk_t                 start_mode;
    logic [VALUE_BITS-1:0] start_val;
    logic [PW-1:0]         start_k, start_l, start_r;
    logic [PW-1:0]         fin_la, fin_rb, fin_cnt;
    logic [VALUE_BITS-1:0] fin_ans;
    logic                  upd_b;
    logic [PW-1:0]         knew;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        out_next       = out_reg;
        len_next       = len_reg;
        zc_next        = zc_reg;
        act_next       = act_reg;
        l0_next        = l0_reg;
        r0_next        = r0_reg;
        x_next         = x_reg;
        second_next    = second_reg;
        mode_next      = mode_reg;
        wv_next        = wv_reg;
        k_next         = k_reg;
        lv_next        = lv_reg;
        w_next         = w_reg;
        la_next        = la_reg;
        rb_next        = rb_reg;
        onesa_next     = onesa_reg;
        onesb_next     = onesb_reg;
        cnt_next       = cnt_reg;
        tmp_next       = tmp_reg;
        ans_next       = ans_reg;
        carry_next     = carry_reg;
        bit_next       = bit_reg;
        dcnt_next      = dcnt_reg;
        dval_next      = dval_reg;
        dfound_next    = dfound_reg;
        derr_next      = derr_reg;
        ram_we         = 1'b0;
        ram_wdata      = ins_word;
        start_walk     = 1'b0;
        start_mode     = WALK_BELOW;
        start_val      = x_reg;
        start_k        = '0;
        start_l        = l0_reg;
        start_r        = r0_reg;
        fin_la         = la_reg;
        fin_rb         = rb_reg;
        fin_cnt        = cnt_reg;
        fin_ans        = ans_reg;
        upd_b          = (act_reg == ACT_INSERT) ? x_reg[lv_reg] : bit_reg;
        knew           = upd_b ? one_l : (la_reg - onesa_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    act_next    = req.action;
                    l0_next     = PW'(lc);
                    r0_next     = PW'(rc);
                    x_next      = req_x;
                    second_next = 1'b0;
                    dcnt_next   = '0;
                    dval_next   = '0;
                    dfound_next = 1'b0;
                    derr_next   = 1'b0;
                    start_l     = PW'(lc);
                    start_r     = PW'(rc);
                    start_val   = req_x;
                    state_next  = ST_DONE;
                    priority if (req.action == ACT_INSERT)
                    begin
                        if (pkc > lenc || lenc >= maxc)
                        begin
                            derr_next = 1'b1;
                        end
                        else
                        begin
                            start_walk = 1'b1;
                            start_l    = PW'(pkc);
                            start_r    = PW'(pkc);
                        end
                    end
                    else if (req.action == ACT_ERASE)
                    begin
                        if (pkc >= lenc)
                        begin
                            derr_next = 1'b1;
                        end
                        else
                        begin
                            start_walk = 1'b1;
                            start_l    = PW'(pkc);
                            start_r    = PW'(pkc);
                        end
                    end
                    else if (lc >= rc || rc > lenc)
                    begin
                        derr_next = 1'b1;
                    end
                    else if (req.action == ACT_EQ)
                    begin
                        start_walk = 1'b1;
                        start_mode = WALK_EQ;
                    end
                    else if (req.action == ACT_BELOW || req.action == ACT_LEAST)
                    begin
                        start_walk = 1'b1;
                    end
                    else if (req.action == ACT_RANGE)
                    begin
                        // larger bound first, then the smaller one
                        if (req_x < req_y)
                        begin
                            start_walk = 1'b1;
                            start_val  = req_y;
                        end
                    end
                    else if (req.action == ACT_KTH)
                    begin
                        if (pkc >= spanc)
                        begin
                            derr_next = 1'b1;
                        end
                        else
                        begin
                            start_walk = 1'b1;
                            start_mode = WALK_KTH;
                            start_k    = PW'(pkc);
                        end
                    end
                    else
                    begin
                        // greatest at most the top value: whole range qualifies
                        start_walk = 1'b1;
                        if (req_x == TOP)
                        begin
                            start_mode  = WALK_KTH;
                            start_k     = PW'(spanc - CW'(1));
                            second_next = 1'b1;
                        end
                        else
                        begin
                            start_val = req_x + VALUE_BITS'(1);
                        end
                    end
                end
            end

            ST_SWEEP_RD:
            begin
                state_next = ST_SWEEP_ACC;
            end

            ST_SWEEP_ACC:
            begin
                onesa_next = onesa_reg + pop_a;
                onesb_next = onesb_reg + pop_b;
                if (w_reg == sweep_last)
                begin
                    priority if (act_reg == ACT_INSERT)
                    begin
                        w_next     = k_word;
                        carry_next = 1'b0;
                        state_next = ST_SHIFT_RD;
                    end
                    else if (act_reg == ACT_ERASE)
                    begin
                        w_next     = ers_first;
                        carry_next = 1'b0;
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = ST_LEVEL;
                    end
                end
                else
                begin
                    w_next     = w_reg + WW'(1);
                    state_next = ST_SWEEP_RD;
                end
            end

            ST_SHIFT_RD:
            begin
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR:
            begin
                ram_we = 1'b1;
                if (act_reg == ACT_INSERT)
                begin
                    // ascending, bit 63 carries into the next word
                    ram_wdata  = (w_reg == k_word) ? ins_word : up_shift;
                    carry_next = ram_rdata[WORD_BITS-1];
                    if (w_reg == ins_last)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        w_next     = w_reg + WW'(1);
                        state_next = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    // descending, bit 0 carries into the word below
                    carry_next = ram_rdata[0];
                    if (w_reg == k_word)
                    begin
                        ram_wdata  = ers_word;
                        bit_next   = ram_rdata[la_reg[5:0]];
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        ram_wdata  = dn_shift;
                        w_next     = w_reg - WW'(1);
                        state_next = ST_SHIFT_RD;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (!upd_b)
                begin
                    zc_next[lv_reg] = (act_reg == ACT_INSERT) ? zc_cur + PW'(1)
                                                               : zc_cur - PW'(1);
                end
                la_next    = knew;
                rb_next    = knew;
                onesa_next = '0;
                onesb_next = '0;
                w_next     = '0;
                if (lv_reg == '0)
                begin
                    len_next   = (act_reg == ACT_INSERT) ? len_reg + PW'(1)
                                                         : len_reg - PW'(1);
                    state_next = ST_DONE;
                end
                else
                begin
                    lv_next    = lv_reg - LW'(1);
                    state_next = ST_SWEEP_RD;
                end
            end

            ST_LEVEL:
            begin
                if (mode_reg == WALK_KTH)
                begin
                    if (span <= k_reg)
                    begin
                        k_next          = k_reg - span;
                        fin_la          = one_l;
                        fin_rb          = one_r;
                        fin_ans[lv_reg] = 1'b1;
                    end
                    else
                    begin
                        fin_la = zl;
                        fin_rb = zr;
                    end
                end
                else
                begin
                    if (wv_reg[lv_reg])
                    begin
                        fin_cnt = cnt_reg + span;
                        fin_la  = one_l;
                        fin_rb  = one_r;
                    end
                    else
                    begin
                        fin_la = zl;
                        fin_rb = zr;
                    end
                end
                la_next    = fin_la;
                rb_next    = fin_rb;
                cnt_next   = fin_cnt;
                ans_next   = fin_ans;
                onesa_next = '0;
                onesb_next = '0;
                w_next     = '0;
                if (lv_reg != '0)
                begin
                    lv_next    = lv_reg - LW'(1);
                    state_next = ST_SWEEP_RD;
                end
                else
                begin
                    state_next = ST_DONE;
                    unique case (act_reg)
                        ACT_EQ:
                        begin
                            dcnt_next = fin_rb - fin_la;
                        end
                        ACT_BELOW:
                        begin
                            dcnt_next = fin_cnt;
                        end
                        ACT_RANGE:
                        begin
                            if (!second_reg)
                            begin
                                tmp_next    = fin_cnt;
                                second_next = 1'b1;
                                start_walk  = 1'b1;
                            end
                            else
                            begin
                                dcnt_next = tmp_reg - fin_cnt;
                            end
                        end
                        ACT_KTH:
                        begin
                            dval_next   = fin_ans;
                            dfound_next = 1'b1;
                        end
                        ACT_LEAST:
                        begin
                            if (second_reg)
                            begin
                                dval_next   = fin_ans;
                                dfound_next = 1'b1;
                            end
                            else if (fin_cnt == r0_reg - l0_reg)
                            begin
                                dval_next = TOP;
                            end
                            else
                            begin
                                start_walk  = 1'b1;
                                start_mode  = WALK_KTH;
                                start_k     = fin_cnt;
                                second_next = 1'b1;
                            end
                        end
                        ACT_GREATEST:
                        begin
                            if (second_reg)
                            begin
                                dval_next   = fin_ans;
                                dfound_next = 1'b1;
                            end
                            else if (fin_cnt != '0)
                            begin
                                start_walk  = 1'b1;
                                start_mode  = WALK_KTH;
                                start_k     = fin_cnt - PW'(1);
                                second_next = 1'b1;
                            end
                        end
                        ACT_INSERT, ACT_ERASE:
                        begin
                            dcnt_next = '0;
                        end
                    endcase
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next        = 1'b1;
                    out_next.count_result = cnt_w[POS_W-1:0];
                    out_next.value_result = val_w[VAL_W-1:0];
                    out_next.found        = dfound_reg;
                    out_next.error        = derr_reg;
                    out_next.length_now   = len_w[POS_W-1:0];
                    state_next            = ST_IDLE;
                end
            end
        endcase

        if (start_walk)
        begin
            mode_next  = start_mode;
            wv_next    = start_val;
            k_next     = start_k;
            la_next    = start_l;
            rb_next    = start_r;
            lv_next    = LW'(VALUE_BITS - 1);
            w_next     = '0;
            onesa_next = '0;
            onesb_next = '0;
            cnt_next   = '0;
            ans_next   = '0;
            state_next = ST_SWEEP_RD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            zc_reg        <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            len_reg       <= len_next;
            zc_reg        <= zc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        act_reg    <= act_next;
        l0_reg     <= l0_next;
        r0_reg     <= r0_next;
        x_reg      <= x_next;
        second_reg <= second_next;
        mode_reg   <= mode_next;
        wv_reg     <= wv_next;
        k_reg      <= k_next;
        lv_reg     <= lv_next;
        w_reg      <= w_next;
        la_reg     <= la_next;
        rb_reg     <= rb_next;
        onesa_reg  <= onesa_next;
        onesb_reg  <= onesb_next;
        cnt_reg    <= cnt_next;
        tmp_reg    <= tmp_next;
        ans_reg    <= ans_next;
        carry_reg  <= carry_next;
        bit_reg    <= bit_next;
        dcnt_reg   <= dcnt_next;
        dval_reg   <= dval_next;
        dfound_reg <= dfound_next;
        derr_reg   <= derr_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// File: hw/rtl/dwm_plane_ram.sv
module dwm_plane_ram
    import dwm_pkg::*;
#(
    parameter int AW = 8
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] plane_mem [1 << AW];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            plane_mem[waddr] <= wdata;
        end
        rdata_reg <= plane_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/dwm_checker.sv
module dwm_checker
    import dwm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      req_valid,
    input logic      req_stall,
    input req_item_t req,
    input logic      rsp_valid,
    input logic      rsp_stall,
    input rsp_item_t rsp
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("rsp item changed while stalled");

    // one item at a time: busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("req taken while previous item in flight");

    // an error result carries no answer
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.error |->
            rsp.count_result == '0 && rsp.value_result == '0 && !rsp.found)
        else $error("error item with answer fields set");

    // found and error exclude each other, and a found result carries no count
    a_found_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> !rsp.error && rsp.count_result == '0)
        else $error("found item flagged as error or with a count");

endmodule

bind dynamic_wavelet_matrix dwm_checker u_dwm_checker (.*);

// File: bench/dwm_checker.sv
module dwm_scoreboard
    import dwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  req_item_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  rsp_item_t rsp,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_MAX = 1024;
    localparam logic [VAL_W-1:0] TOP = 16'hFFFF;

    // shadow model kept as a plain array of values
    logic [VAL_W-1:0] seq_vals [LEN_MAX];
    int               seq_len;
    rsp_item_t        want_q [$];

    function automatic int below_cnt(int l, int r, logic [16:0] x);
        int c;
        c = 0;
        for (int i = l; i < r; i++)
            if ({1'b0, seq_vals[i]} < x) c++;
        return c;
    endfunction

    function automatic logic [VAL_W-1:0] kth_val(int l, int r, int k);
        logic [VAL_W-1:0] tmp [$];
        for (int i = l; i < r; i++) tmp = {tmp, seq_vals[i]};
        tmp.sort();
        return tmp[k];
    endfunction

    task automatic predict_item(input req_item_t it);
        rsp_item_t o;
        int pk, l, r, idx;
        o  = '0;
        pk = int'(it.pos_or_rank);
        l  = int'(it.range_start);
        r  = int'(it.range_end);
        case (it.action)
            ACT_INSERT:
                if (pk > seq_len || seq_len >= LEN_MAX) o.error = 1'b1;
                else
                begin
                    for (int p = seq_len; p > pk; p--) seq_vals[p] = seq_vals[p-1];
                    seq_vals[pk] = it.value_low;
                    seq_len++;
                end
            ACT_ERASE:
                if (pk >= seq_len) o.error = 1'b1;
                else
                begin
                    for (int p = pk; p + 1 < seq_len; p++) seq_vals[p] = seq_vals[p+1];
                    seq_len--;
                end
            default:
                if (l >= r || r > seq_len) o.error = 1'b1;
                else
                    case (it.action)
                        ACT_EQ:
                            o.count_result = POS_W'(below_cnt(l, r, it.value_low + 17'd1)
                                - below_cnt(l, r, it.value_low));
                        ACT_BELOW:
                            o.count_result = POS_W'(below_cnt(l, r, it.value_low));
                        ACT_RANGE:
                            if (it.value_low < it.value_high)
                                o.count_result = POS_W'(below_cnt(l, r, it.value_high)
                                    - below_cnt(l, r, it.value_low));
                        ACT_KTH:
                            if (pk >= r - l) o.error = 1'b1;
                            else
                            begin
                                o.value_result = kth_val(l, r, pk);
                                o.found = 1'b1;
                            end
                        ACT_LEAST:
                        begin
                            idx = below_cnt(l, r, it.value_low);
                            if (idx == r - l) o.value_result = TOP;
                            else
                            begin
                                o.value_result = kth_val(l, r, idx);
                                o.found = 1'b1;
                            end
                        end
                        default:
                        begin
                            idx = below_cnt(l, r, it.value_low + 17'd1);
                            if (idx != 0)
                            begin
                                o.value_result = kth_val(l, r, idx - 1);
                                o.found = 1'b1;
                            end
                        end
                    endcase
        endcase
        o.length_now = POS_W'(seq_len);
        want_q = {want_q, o};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t w;
        if (!rst_n)
        begin
            seq_len    <= 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (req_valid && !req_stall) predict_item(req);
            if (rsp_valid && !rsp_stall)
            begin
                if (want_q.size() == 0)
                begin
                    $display("%0t: unexpected item %h", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    w = want_q.pop_front();
                    if (w !== rsp)
                    begin
                        $display("%0t: mismatch expected cnt=%0d val=%h fnd=%b err=%b len=%0d",
                            $time, w.count_result, w.value_result, w.found, w.error,
                            w.length_now);
                        $display("%0t:            actual cnt=%0d val=%h fnd=%b err=%b len=%0d",
                            $time, rsp.count_result, rsp.value_result, rsp.found,
                            rsp.error, rsp.length_now);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= want_q.size();
        end
    end
endmodule

// File: bench/dynamic_wavelet_matrix_tb.sv
module dynamic_wavelet_matrix_tb
    import dwm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;
    int        fail_count;
    int        pending;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        sent;
    rsp_item_t last_rsp;

    dynamic_wavelet_matrix u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // watches both channels, predicts and compares
    dwm_scoreboard u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stall, redrawn every cycle
    always @(posedge clk or negedge rst_n)
        if (!rst_n) rsp_stall <= 1'b0;
        else rsp_stall <= ($urandom_range(99) < recv_stall_pct);

    // length tracked from the last accepted result when one is available;
    // a stale value only makes some random positions fall out of range
    always @(posedge clk or negedge rst_n)
        if (!rst_n) last_rsp <= '0;
        else if (rsp_valid && !rsp_stall) last_rsp <= rsp;

    function automatic int u_chk_len();
        return int'(last_rsp.length_now);
    endfunction

    // hand one item over, honoring the sender idle rate;
    // valid stays up when the next item follows at once
    task automatic send_item(input req_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent++;
    endtask

    function automatic req_item_t make_item(input action_t a, input int p, input int l,
                                            input int r, input int x, input int y);
        req_item_t it;
        it.action      = a;
        it.pos_or_rank = POS_W'(p);
        it.range_start = POS_W'(l);
        it.range_end   = POS_W'(r);
        it.value_low   = VAL_W'(x);
        it.value_high  = VAL_W'(y);
        return it;
    endfunction

    // random item: mostly valid positions/ranges near a tracked length,
    // some raw noise with any bit pattern
    function automatic req_item_t rand_item(input int len);
        req_item_t it;
        int l, r;
        it = req_item_t'($bits(req_item_t)'({$urandom, $urandom, $urandom}));
        if ($urandom_range(9) == 0) return it;
        it.action = action_t'($urandom_range(7));
        if ($urandom_range(3) == 0) it.value_low = VAL_W'($urandom_range(15) * 4369);
        if (it.action == ACT_INSERT && $urandom_range(1))
            it.pos_or_rank = POS_W'($urandom_range(len));
        else if (it.action == ACT_ERASE)
            it.pos_or_rank = POS_W'(len == 0 ? 0 : $urandom_range(len - 1));
        else if (len > 0)
        begin
            l = $urandom_range(len - 1);
            r = $urandom_range(len, l + 1);
            it.range_start = POS_W'(l);
            it.range_end   = POS_W'(r);
            it.pos_or_rank = POS_W'($urandom_range(r - l));
        end
        return it;
    endfunction

    initial
    begin
        int len;
        req_valid      = 1'b0;
        req            = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sent           = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty store errors, extremes, every action
        send_item(make_item(ACT_ERASE, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_EQ, 0, 0, 1, 0, 0));
        send_item(make_item(ACT_INSERT, 1, 0, 0, 5, 0));
        send_item(make_item(ACT_INSERT, 0, 0, 0, 16'hFFFF, 0));
        send_item(make_item(ACT_INSERT, 0, 0, 0, 0, 0));
        send_item(make_item(ACT_INSERT, 1, 0, 0, 16'h8000, 0));
        send_item(make_item(ACT_INSERT, 4, 0, 0, 7, 0));
        send_item(make_item(ACT_INSERT, 2, 0, 0, 16'h8000, 0));
        send_item(make_item(ACT_EQ, 0, 0, 5, 16'h8000, 0));
        send_item(make_item(ACT_BELOW, 0, 1, 5, 16'hFFFF, 0));
        send_item(make_item(ACT_RANGE, 0, 0, 5, 1, 16'hFFFF));
        send_item(make_item(ACT_RANGE, 0, 0, 5, 9, 9));
        send_item(make_item(ACT_KTH, 0, 0, 5, 0, 0));
        send_item(make_item(ACT_KTH, 4, 0, 5, 0, 0));
        send_item(make_item(ACT_KTH, 5, 0, 5, 0, 0));
        send_item(make_item(ACT_LEAST, 0, 0, 5, 16'h8001, 0));
        send_item(make_item(ACT_LEAST, 0, 0, 4, 16'hFFFF, 0));
        send_item(make_item(ACT_GREATEST, 0, 0, 5, 16'hFFFF, 0));
        send_item(make_item(ACT_GREATEST, 0, 1, 5, 6, 0));
        send_item(make_item(ACT_GREATEST, 0, 2, 4, 0, 0));
        send_item(make_item(ACT_EQ, 0, 3, 3, 0, 0));
        send_item(make_item(ACT_BELOW, 0, 0, 6, 0, 0));
        send_item(make_item(ACT_ERASE, 5, 0, 0, 0, 0));
        send_item(make_item(ACT_ERASE, 4, 0, 0, 0, 0));
        send_item(make_item(ACT_ERASE, 0, 0, 0, 0, 0));
        len = 3;

        // random phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 87 : (ph == 3) ? 11 : 0;
            recv_stall_pct = (ph == 2) ? 87 : (ph == 3) ? 11 : 0;
            for (int n = 0; n < 112; n++)
            begin
                send_item(rand_item(len));
                len = u_chk_len();
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d items over all eight actions, error cases and four", sent);
        $display("idle/stall phases, ending with a store length of %0d", len);
        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
